// ----- src/i2cms_pkg.sv -----
// shared types and constants for the i2c master bit sequencer
package i2cms_pkg;

    // command codes carried by req_type and held while a sequence runs
    typedef enum logic [2:0] {
        CMD_IDLE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_READ  = 3'd3,
        CMD_WAIT  = 3'd4
    } cmd_t;

    localparam int unsigned BITS_PER_BYTE = 8;
    localparam int unsigned PHASE_W       = 5;
    localparam logic [7:0]  TIMEOUT_RESET = 8'd250;

    // first phase after the data bits of a read
    localparam logic [PHASE_W-1:0] READ_ACK_PHASE = PHASE_W'(2 * BITS_PER_BYTE);

    // sequencer state carried from tick to tick
    typedef struct packed {
        cmd_t               cmd;
        logic [PHASE_W-1:0] phase;
        logic [7:0]         shift_byte;
        logic [7:0]         poll_count;
        logic               send_ack;
        logic               scl_level;
        logic               sda_level;
        logic               fail_flag;
    } seq_state_t;

    // per-tick status flags
    typedef struct packed {
        logic busy;
        logic done;
    } seq_flags_t;

endpackage

// ----- src/i2cms_step.sv -----
// one tick of the i2c bit sequencer: next state and status from one word
module i2cms_step
    import i2cms_pkg::*;
(
    input  seq_state_t cur,
    input  logic [2:0] req_type,
    input  logic       ack_after_read,
    input  logic       sda_in,
    input  logic [7:0] ack_timeout,
    output seq_state_t nxt,
    output seq_flags_t flags
);

    logic [PHASE_W-1:0] ack_step;

    always_comb
    begin
        nxt        = cur;
        flags.busy = 1'b0;
        flags.done = 1'b0;
        ack_step   = '0;

        // command pickup when idle; undefined codes act as no request
        if (cur.cmd == CMD_IDLE &&
            (req_type == CMD_START || req_type == CMD_STOP ||
             req_type == CMD_READ  || req_type == CMD_WAIT))
        begin
            nxt.cmd        = cmd_t'(req_type);
            nxt.phase      = '0;
            nxt.poll_count = '0;
            nxt.send_ack   = ack_after_read;
            if (req_type == CMD_READ)
            begin
                nxt.shift_byte = '0;
            end
        end

        // run the step for the current phase
        if (nxt.cmd != CMD_IDLE)
        begin
            flags.busy = 1'b1;
            case (nxt.cmd)
                CMD_START:
                begin
                    case (nxt.phase)
                        PHASE_W'(0):
                        begin
                            nxt.sda_level = 1'b1;
                            nxt.scl_level = 1'b1;
                            nxt.phase     = PHASE_W'(1);
                        end
                        PHASE_W'(1):
                        begin
                            nxt.sda_level = 1'b0;
                            nxt.phase     = PHASE_W'(2);
                        end
                        default:
                        begin
                            nxt.scl_level = 1'b0;
                            flags.done    = 1'b1;
                            nxt.cmd       = CMD_IDLE;
                            nxt.phase     = '0;
                        end
                    endcase
                end
                CMD_STOP:
                begin
                    case (nxt.phase)
                        PHASE_W'(0):
                        begin
                            nxt.sda_level = 1'b0;
                            nxt.phase     = PHASE_W'(1);
                        end
                        PHASE_W'(1):
                        begin
                            nxt.scl_level = 1'b1;
                            nxt.phase     = PHASE_W'(2);
                        end
                        default:
                        begin
                            nxt.sda_level = 1'b1;
                            flags.done    = 1'b1;
                            nxt.cmd       = CMD_IDLE;
                            nxt.phase     = '0;
                        end
                    endcase
                end
                CMD_READ:
                begin
                    if (nxt.phase < READ_ACK_PHASE)
                    begin
                        // data bits: sample on scl high, drop scl on odd phases
                        if (!nxt.phase[0])
                        begin
                            nxt.scl_level  = 1'b1;
                            nxt.shift_byte = {nxt.shift_byte[6:0], sda_in};
                        end
                        else
                        begin
                            nxt.scl_level = 1'b0;
                        end
                        nxt.phase = nxt.phase + PHASE_W'(1);
                    end
                    else
                    begin
                        // ack or nack bit after the byte
                        ack_step = nxt.phase - READ_ACK_PHASE;
                        case (ack_step)
                            PHASE_W'(0):
                            begin
                                nxt.sda_level = ~nxt.send_ack;
                                nxt.phase     = nxt.phase + PHASE_W'(1);
                            end
                            PHASE_W'(1):
                            begin
                                nxt.scl_level = 1'b1;
                                nxt.phase     = nxt.phase + PHASE_W'(1);
                            end
                            PHASE_W'(2):
                            begin
                                nxt.scl_level = 1'b0;
                                if (nxt.send_ack)
                                begin
                                    nxt.phase = nxt.phase + PHASE_W'(1);
                                end
                                else
                                begin
                                    flags.done = 1'b1;
                                    nxt.cmd    = CMD_IDLE;
                                    nxt.phase  = '0;
                                end
                            end
                            default:
                            begin
                                nxt.sda_level = 1'b1;
                                flags.done    = 1'b1;
                                nxt.cmd       = CMD_IDLE;
                                nxt.phase     = '0;
                            end
                        endcase
                    end
                end
                default:
                begin
                    // wait for ack: poll sda with scl high, stop on timeout
                    case (nxt.phase)
                        PHASE_W'(0):
                        begin
                            nxt.sda_level = 1'b1;
                            nxt.phase     = PHASE_W'(1);
                        end
                        PHASE_W'(1), PHASE_W'(2):
                        begin
                            if (nxt.phase == PHASE_W'(1))
                            begin
                                nxt.scl_level = 1'b1;
                            end
                            if (!sda_in)
                            begin
                                nxt.phase = PHASE_W'(3);
                            end
                            else if (nxt.poll_count >= ack_timeout)
                            begin
                                nxt.phase = PHASE_W'(4);
                            end
                            else
                            begin
                                nxt.poll_count = nxt.poll_count + 8'd1;
                                nxt.phase      = PHASE_W'(2);
                            end
                        end
                        PHASE_W'(3):
                        begin
                            nxt.scl_level = 1'b0;
                            nxt.fail_flag = 1'b0;
                            flags.done    = 1'b1;
                            nxt.cmd       = CMD_IDLE;
                            nxt.phase     = '0;
                        end
                        PHASE_W'(4):
                        begin
                            nxt.sda_level = 1'b0;
                            nxt.phase     = PHASE_W'(5);
                        end
                        PHASE_W'(5):
                        begin
                            nxt.scl_level = 1'b1;
                            nxt.phase     = PHASE_W'(6);
                        end
                        PHASE_W'(6):
                        begin
                            nxt.sda_level = 1'b1;
                            nxt.phase     = PHASE_W'(7);
                        end
                        default:
                        begin
                            nxt.scl_level = 1'b0;
                            nxt.fail_flag = 1'b1;
                            flags.done    = 1'b1;
                            nxt.cmd       = CMD_IDLE;
                            nxt.phase     = '0;
                        end
                    endcase
                end
            endcase
        end
    end

endmodule

// ----- src/i2c_master_bit_sequencer.sv -----
// i2c master bit sequencer: input register, tick step logic, result register
// a word held in the input register passes through the step logic into the result register
// when the result register is empty or its result is being taken
// throughput: one word per cycle while results are taken; the sequencer state register closes the loop
// a full input register waits while a result waits; an empty one still takes a word
// reset: sequencer idle with scl and sda levels high, ack timeout 250, no words held
module i2c_master_bit_sequencer
    import i2cms_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] req_type,
    input  logic       ack_after_read,
    input  logic       sda_in,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       scl_out,
    output logic       sda_out,
    output logic       busy_res,
    output logic       done_res,
    output logic [7:0] read_data,
    output logic       ack_failed,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata
);

    logic       in_valid_reg;
    logic [2:0] req_reg;
    logic       ack_reg;
    logic       sda_reg;
    logic       out_valid_reg;
    logic [7:0] timeout_reg;
    seq_state_t state_reg;
    seq_state_t state_next;
    seq_flags_t flags;
    logic       scl_reg;
    logic       sda_out_reg;
    logic       busy_reg;
    logic       done_reg;
    logic [7:0] data_reg;
    logic       fail_reg;
    logic       advance;

    // word moves from the input register into the result register
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    i2cms_step u_step (
        .cur            (state_reg),
        .req_type       (req_reg),
        .ack_after_read (ack_reg),
        .sda_in         (sda_reg),
        .ack_timeout    (timeout_reg),
        .nxt            (state_next),
        .flags          (flags)
    );

    // control: valid flags, sequencer state, timeout register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg         <= 1'b0;
            out_valid_reg        <= 1'b0;
            timeout_reg          <= TIMEOUT_RESET;
            state_reg.cmd        <= CMD_IDLE;
            state_reg.phase      <= '0;
            state_reg.shift_byte <= '0;
            state_reg.poll_count <= '0;
            state_reg.send_ack   <= 1'b0;
            state_reg.scl_level  <= 1'b1;
            state_reg.sda_level  <= 1'b1;
            state_reg.fail_flag  <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                timeout_reg <= cfg_wdata;
            end
        end
    end

    // payload: input word and result word
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            req_reg <= req_type;
            ack_reg <= ack_after_read;
            sda_reg <= sda_in;
        end
        if (advance)
        begin
            scl_reg     <= state_next.scl_level;
            sda_out_reg <= state_next.sda_level;
            busy_reg    <= flags.busy;
            done_reg    <= flags.done;
            data_reg    <= state_next.shift_byte;
            fail_reg    <= state_next.fail_flag;
        end
    end

    assign out_valid  = out_valid_reg;
    assign scl_out    = scl_reg;
    assign sda_out    = sda_out_reg;
    assign busy_res   = busy_reg;
    assign done_res   = done_reg;
    assign read_data  = data_reg;
    assign ack_failed = fail_reg;

endmodule
